/* rtl/evpp_pkg.sv */
// Shared types and constants of the encoder velocity PID/PWM core.
// Holds register indexes, the configuration record, the controller state
// and the command and status records. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package evpp_pkg;

  // Field and datapath widths.
  localparam int CountW   = 32;
  localparam int VelW     = 32;
  localparam int PwmW     = 16;
  localparam int GainW    = 16;
  localparam int LimW     = 15;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegKpGain     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKdGain     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKiGain     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRange      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMaxPwm     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegVelScale   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegFfGain     = 3'd6;
  localparam logic [CfgIdxW-1:0] RegEncPresent = 3'd7;

  // Configuration record.
  typedef struct packed {
    logic [GainW-1:0]  kp_gain;
    logic [GainW-1:0]  kd_gain;
    logic [GainW-1:0]  ki_gain;
    logic [CountW-1:0] encoder_range;
    logic [LimW-1:0]   max_pwm;
    logic [31:0]       velocity_scale;
    logic [31:0]       feedforward_gain;
    logic              encoder_present;
  } cfg_t;

  // Controller states.
  typedef enum logic [3:0] {
    StIdle,
    StUnwrap,
    StVelMul,
    StVelDiff,
    StErrSum,
    StKpMul,
    StKdMul,
    StKiMul,
    StAccum,
    StFinish,
    StFfMul,
    StFfFinish
  } state_e;

  // Operand selection of the shared multiplier.
  typedef enum logic [2:0] {
    MulVel,
    MulFf,
    MulKp,
    MulKd,
    MulKi
  } mul_sel_e;

  // Accumulator operation.
  typedef enum logic [1:0] {
    AccHold,
    AccLoad,
    AccAdd
  } acc_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_in;
    logic     unwrap_en;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     diff_en;
    logic     err_en;
    acc_op_e  acc_op;
    logic     fin_closed;
    logic     fin_open;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic enc_present;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/evpp_in_if.sv */
// Input channel of the encoder velocity PID/PWM core.
// Carries valid, ready and one input transaction; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface evpp_in_if;
  logic               valid;
  logic               ready;
  logic        [31:0] encoder_count;
  logic signed [31:0] target_velocity;

  modport source (output valid, output encoder_count, output target_velocity, input ready);
  modport sink   (input valid, input encoder_count, input target_velocity, output ready);
endinterface

`default_nettype wire

/* rtl/evpp_out_if.sv */
// Output channel of the encoder velocity PID/PWM core.
// Carries valid, ready and one PWM result transaction; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface evpp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pwm_value;

  modport source (output valid, output pwm_value, input ready);
  modport sink   (input valid, input pwm_value, output ready);
endinterface

`default_nettype wire

/* rtl/evpp_cfg_regs.sv */
// Configuration register file of the encoder velocity PID/PWM core.
// Depends on evpp_pkg for the register indexes and the cfg_t record.
`timescale 1ns / 1ps
`default_nettype none

module evpp_cfg_regs (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [evpp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire  [evpp_pkg::CfgDataW-1:0]  cfg_data_i,
  output evpp_pkg::cfg_t                 cfg_o
);
  import evpp_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode a write into the addressed register.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegKpGain:     cfg_d.kp_gain          = cfg_data_i[GainW-1:0];
        RegKdGain:     cfg_d.kd_gain          = cfg_data_i[GainW-1:0];
        RegKiGain:     cfg_d.ki_gain          = cfg_data_i[GainW-1:0];
        RegRange:      cfg_d.encoder_range    = cfg_data_i[CountW-1:0];
        RegMaxPwm:     cfg_d.max_pwm          = cfg_data_i[LimW-1:0];
        RegVelScale:   cfg_d.velocity_scale   = cfg_data_i[31:0];
        RegFfGain:     cfg_d.feedforward_gain = cfg_data_i[31:0];
        RegEncPresent: cfg_d.encoder_present  = cfg_data_i[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  // Registers with their reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp_gain          <= '0;
      cfg_q.kd_gain          <= '0;
      cfg_q.ki_gain          <= '0;
      cfg_q.encoder_range    <= 32'd4096;
      cfg_q.max_pwm          <= 15'd1000;
      cfg_q.velocity_scale   <= '0;
      cfg_q.feedforward_gain <= '0;
      cfg_q.encoder_present  <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/evpp_ctrl.sv */
// Sequencing state machine of the encoder velocity PID/PWM core.
// Depends on evpp_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module evpp_ctrl (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire evpp_pkg::dp_status_t status_i,
  output evpp_pkg::ctrl_cmd_t     cmd_o
);
  import evpp_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = status_i.enc_present ? StUnwrap : StFfMul;
        end
      end
      StUnwrap:   state_d = StVelMul;
      StVelMul:   state_d = StVelDiff;
      StVelDiff:  state_d = StErrSum;
      StErrSum:   state_d = StKpMul;
      StKpMul:    state_d = StKdMul;
      StKdMul:    state_d = StKiMul;
      StKiMul:    state_d = StAccum;
      StAccum:    state_d = StFinish;
      StFinish: begin
        if (!status_i.out_busy) begin
          state_d = StIdle;
        end
      end
      StFfMul:    state_d = StFfFinish;
      StFfFinish: begin
        if (!status_i.out_busy) begin
          state_d = StIdle;
        end
      end
      default:    state_d = StIdle;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MulVel;
    cmd_o.acc_op  = AccHold;
    unique case (state_q)
      StIdle:     cmd_o.load_in   = accept;
      StUnwrap:   cmd_o.unwrap_en = 1'b1;
      StVelMul: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulVel;
      end
      StVelDiff:  cmd_o.diff_en   = 1'b1;
      StErrSum:   cmd_o.err_en    = 1'b1;
      StKpMul: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulKp;
      end
      StKdMul: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulKd;
        cmd_o.acc_op  = AccLoad;
      end
      StKiMul: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulKi;
        cmd_o.acc_op  = AccAdd;
      end
      StAccum:    cmd_o.acc_op     = AccAdd;
      StFinish:   cmd_o.fin_closed = !status_i.out_busy;
      StFfMul: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulFf;
      end
      StFfFinish: cmd_o.fin_open   = !status_i.out_busy;
      default:    cmd_o.load_in    = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/evpp_dp.sv */
// Datapath of the encoder velocity PID/PWM core: count unwrapping, the shared
// multiplier, error conversion, the PWM accumulator and the output register.
// Depends on evpp_pkg for the configuration, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module evpp_dp (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire evpp_pkg::cfg_t           cfg_i,
  input  wire evpp_pkg::ctrl_cmd_t      cmd_i,
  output evpp_pkg::dp_status_t          status_o,
  input  wire  [evpp_pkg::CountW-1:0]   encoder_count_i,
  input  wire  signed [evpp_pkg::VelW-1:0] target_velocity_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic signed [evpp_pkg::PwmW-1:0] pwm_value_o
);
  import evpp_pkg::*;

  // Saturation to the symmetric limit of max_pwm.
  function automatic logic signed [15:0] clamp_lim(input logic signed [39:0] v,
                                                   input logic [14:0] lim);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = $signed({25'd0, lim});
    lo = -hi;
    if (v > hi) begin
      return hi[15:0];
    end else if (v < lo) begin
      return lo[15:0];
    end else begin
      return v[15:0];
    end
  endfunction

  // Low band: count * 10 <= range.
  function automatic logic in_low_band(input logic [31:0] c, input logic [31:0] r);
    logic [35:0] c10;
    c10 = {1'b0, c, 3'b000} + {3'b000, c, 1'b0};
    return c10 <= {4'd0, r};
  endfunction

  // High band: count <= range and count * 10 >= range * 9.
  function automatic logic in_high_band(input logic [31:0] c, input logic [31:0] r);
    logic [35:0] c10;
    logic [35:0] r9;
    c10 = {1'b0, c, 3'b000} + {3'b000, c, 1'b0};
    r9  = {1'b0, r, 3'b000} + {4'd0, r};
    return (c <= r) && (c10 >= r9);
  endfunction

  localparam logic [63:0] VelLimit = 64'h0001_0000_0000_0000;

  // Controller state of the loop.
  logic        [31:0] prev_count_q;
  logic signed [15:0] err_sum_q;
  logic signed [15:0] prev_err_q;
  logic signed [15:0] pwm_acc_q;
  logic               out_valid_q, out_valid_d;

  // Working registers of one transaction.
  logic        [31:0] cur_q;
  logic signed [31:0] tgt_q;
  logic        [31:0] mag_q, mag_d;
  logic               neg_q, neg_d;
  logic signed [65:0] prod_q, prod_d;
  logic signed [49:0] diff_q, diff_d;
  logic signed [15:0] err_q, err_d;
  logic signed [15:0] sum_q, sum_d;
  logic signed [39:0] acc_q, acc_d;
  logic signed [15:0] out_data_q;
  logic signed [15:0] pwm_d;
  logic signed [15:0] ff_pwm;

  logic signed [32:0] mul_a, mul_b;
  logic signed [16:0] derr;

  // Count delta, unwrapped across the turn boundary.
  logic signed [34:0] delta_raw, delta, abs_delta;
  logic signed [34:0] range_s;

  always_comb begin
    range_s   = $signed({3'b000, cfg_i.encoder_range});
    delta_raw = $signed({3'b000, cur_q}) - $signed({3'b000, prev_count_q});
    if (in_low_band(cur_q, cfg_i.encoder_range) &&
        in_high_band(prev_count_q, cfg_i.encoder_range)) begin
      delta = delta_raw + range_s;
    end else if (in_high_band(cur_q, cfg_i.encoder_range) &&
                 in_low_band(prev_count_q, cfg_i.encoder_range)) begin
      delta = delta_raw - range_s;
    end else begin
      delta = delta_raw;
    end
    abs_delta = delta[34] ? -delta : delta;
    // The unwrapped delta always stays below one full 32-bit span.
    mag_d = abs_delta[31:0];
    neg_d = delta[34];
  end

  // Operand selection of the shared 33 x 33 signed multiplier.
  always_comb begin
    derr = $signed({err_q[15], err_q}) - $signed({prev_err_q[15], prev_err_q});
    unique case (cmd_i.mul_sel)
      MulVel: begin
        mul_a = $signed({1'b0, mag_q});
        mul_b = $signed({1'b0, cfg_i.velocity_scale});
      end
      MulFf: begin
        mul_a = $signed({tgt_q[31], tgt_q});
        mul_b = $signed({1'b0, cfg_i.feedforward_gain});
      end
      MulKp: begin
        mul_a = $signed({{17{err_q[15]}}, err_q});
        mul_b = $signed({17'd0, cfg_i.kp_gain});
      end
      MulKd: begin
        mul_a = $signed({{16{derr[16]}}, derr});
        mul_b = $signed({17'd0, cfg_i.kd_gain});
      end
      MulKi: begin
        mul_a = $signed({{17{sum_q[15]}}, sum_q});
        mul_b = $signed({17'd0, cfg_i.ki_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  // Velocity, saturated to 2^48, and the velocity error in Q16.16.
  logic        [48:0] vel_sat;
  logic signed [49:0] vel_s;

  always_comb begin
    vel_sat = (prod_q[63:0] > VelLimit) ? VelLimit[48:0] : prod_q[48:0];
    vel_s   = $signed({1'b0, vel_sat});
    if (neg_q) begin
      vel_s = -vel_s;
    end
    diff_d = $signed({{18{tgt_q[31]}}, tgt_q}) - vel_s;
  end

  // Truncation toward zero to an integer, int16 saturation, clamped error sum.
  logic signed [49:0] diff_rnd, diff_int;
  logic signed [39:0] sum_wide;

  always_comb begin
    diff_rnd = diff_q + (diff_q[49] ? 50'sh0FFFF : 50'sh0);
    diff_int = diff_rnd >>> 16;
    if (diff_int > 50'sh07FFF) begin
      err_d = 16'sh7FFF;
    end else if (diff_int < -50'sh08000) begin
      err_d = 16'sh8000;
    end else begin
      err_d = diff_int[15:0];
    end
    sum_wide = $signed({{24{err_sum_q[15]}}, err_sum_q}) + $signed({{24{err_d[15]}}, err_d});
    sum_d    = clamp_lim(sum_wide, cfg_i.max_pwm);
  end

  // PWM accumulator.
  always_comb begin
    unique case (cmd_i.acc_op)
      AccLoad: acc_d = $signed({{24{pwm_acc_q[15]}}, pwm_acc_q}) + prod_q[39:0];
      AccAdd:  acc_d = acc_q + prod_q[39:0];
      default: acc_d = acc_q;
    endcase
    pwm_d = clamp_lim(acc_q, cfg_i.max_pwm);
  end

  // Open loop: product over 2^32, truncated toward zero, then clamped.
  logic signed [65:0] ff_rnd;

  always_comb begin
    ff_rnd = prod_q + (prod_q[65] ? 66'sh0_FFFF_FFFF : 66'sh0);
    ff_pwm = clamp_lim($signed({{6{ff_rnd[65]}}, ff_rnd[65:32]}), cfg_i.max_pwm);
  end

  // Output register hand-off.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.fin_closed || cmd_i.fin_open) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Working registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cur_q <= encoder_count_i;
      tgt_q <= target_velocity_i;
    end
    if (cmd_i.unwrap_en) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.diff_en) begin
      diff_q <= diff_d;
    end
    if (cmd_i.err_en) begin
      err_q <= err_d;
      sum_q <= sum_d;
    end
    acc_q <= acc_d;
    if (cmd_i.fin_closed) begin
      out_data_q <= pwm_d;
    end else if (cmd_i.fin_open) begin
      out_data_q <= ff_pwm;
    end
  end

  // Loop state, committed once the result enters the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_count_q <= '0;
      err_sum_q    <= '0;
      prev_err_q   <= '0;
      pwm_acc_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.fin_closed) begin
        prev_count_q <= cur_q;
        err_sum_q    <= sum_q;
        prev_err_q   <= err_q;
        pwm_acc_q    <= pwm_d;
      end
    end
  end

  assign status_o.enc_present = cfg_i.encoder_present;
  assign status_o.out_busy    = out_valid_q && !out_ready_i;
  assign out_valid_o          = out_valid_q;
  assign pwm_value_o          = out_data_q;

endmodule

`default_nettype wire

/* rtl/encoder_velocity_pid_pwm_core.sv */
// Top level of the encoder velocity PID/PWM core.
// Depends on evpp_pkg, evpp_in_if, evpp_out_if, evpp_cfg_regs, evpp_ctrl and evpp_dp.
`timescale 1ns / 1ps
`default_nettype none

// The core takes one transaction at a time. In closed loop (encoder_present set) a
// transaction steps through unwrap, velocity product and error, error sum, three gain
// products, accumulation and finish before its result is offered; open loop steps
// through the feed-forward product and finish. One shared 33 x 33 multiplier forms
// the velocity, gain and feed-forward products in turn, with a register after each
// product. The result waits in an output register, so a new transaction is accepted
// while the previous result is still unclaimed; a finished result is held back only
// while that register is full. Configuration is to be written through the plain write
// port while the core is idle; the core does not enforce it.

module encoder_velocity_pid_pwm_core (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [evpp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire  [evpp_pkg::CfgDataW-1:0]  cfg_data_i,
  evpp_in_if.sink                        in_i,
  evpp_out_if.source                     out_o
);
  import evpp_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  // Configuration registers.
  evpp_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Sequencer.
  evpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic and loop state.
  evpp_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .cmd_i             (cmd),
    .status_o          (status),
    .encoder_count_i   (in_i.encoder_count),
    .target_velocity_i (in_i.target_velocity),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .pwm_value_o       (out_o.pwm_value)
  );

  assign in_i.ready = in_ready;

endmodule

`default_nettype wire

/* verif/evpp_checker.sv */
// Result checker of the encoder velocity PID/PWM core testbench.
// Watches the configuration port and both channels, predicts each PWM result
// and compares it with the core's output. Depends on evpp_pkg and the channel interfaces.
`timescale 1ns / 1ps

module evpp_checker
  import evpp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  evpp_in_if                  in_i,
  evpp_out_if                 out_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  localparam longint unsigned VelLimit = 64'd1 << 48;

  // Mirrored configuration and controller state.
  cfg_t               cfg_q;
  logic [CountW-1:0]  prev_count_q;
  logic signed [15:0] err_sum_q;
  logic signed [15:0] prev_err_q;
  logic signed [15:0] pwm_acc_q;

  logic signed [PwmW-1:0] pwm_expected[$];
  logic signed [PwmW-1:0] pwm_want;
  int unsigned            fail_count;

  assign fail_count_o = fail_count;

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  function automatic longint clamp_s(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Band tests against the turn boundary, exact in integers.
  function automatic bit low_band(longint unsigned c, longint unsigned r);
    return c * 10 <= r;
  endfunction

  function automatic bit high_band(longint unsigned c, longint unsigned r);
    return (c <= r) && (c * 10 >= r * 9);
  endfunction

  // Work out the PWM drive of one input transaction and advance the state.
  function automatic logic signed [PwmW-1:0] predict_pwm(logic [CountW-1:0] count,
                                                         logic signed [VelW-1:0] target);
    longint          lim, tgt, delta, vel, err, sum, acc, res;
    longint unsigned cur, prev, rng, mag, vs;
    lim = longint'(cfg_q.max_pwm);
    tgt = longint'(target);
    if (!cfg_q.encoder_present) begin
      // Open loop: feed-forward only, no state is touched.
      acc = tgt * longint'(cfg_q.feedforward_gain);
      res = clamp_s(acc / 64'sh1_0000_0000, -lim, lim);
    end else begin
      cur   = count;
      prev  = prev_count_q;
      rng   = cfg_q.encoder_range;
      delta = longint'(cur) - longint'(prev);
      // Unwrap the count delta across the turn boundary.
      if (low_band(cur, rng) && high_band(prev, rng)) begin
        delta = delta + longint'(rng);
      end else if (high_band(cur, rng) && low_band(prev, rng)) begin
        delta = delta - longint'(rng);
      end
      prev_count_q = count;

      // Scale to rad/s, saturating the magnitude at the velocity limit.
      mag = (delta < 0) ? -delta : delta;
      vs  = cfg_q.velocity_scale;
      if (vs != 0 && mag > VelLimit / vs) begin
        vel = longint'(VelLimit);
      end else begin
        vel = longint'(mag * vs);
      end
      if (delta < 0) vel = -vel;

      err = clamp_s((tgt - vel) / 65536, -32768, 32767);
      sum = clamp_s(longint'(err_sum_q) + err, -lim, lim);
      acc = longint'(pwm_acc_q)
          + longint'(cfg_q.kp_gain) * err
          + longint'(cfg_q.kd_gain) * (err - longint'(prev_err_q))
          + longint'(cfg_q.ki_gain) * sum;
      acc = clamp_s(acc, -lim, lim);

      err_sum_q  = sum[15:0];
      pwm_acc_q  = acc[15:0];
      prev_err_q = err[15:0];
      res        = acc;
    end
    return res[PwmW-1:0];
  endfunction

  // Track register writes, predict on each input transaction and check each result.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp_gain          = '0;
      cfg_q.kd_gain          = '0;
      cfg_q.ki_gain          = '0;
      cfg_q.encoder_range    = 32'd4096;
      cfg_q.max_pwm          = 15'd1000;
      cfg_q.velocity_scale   = '0;
      cfg_q.feedforward_gain = '0;
      cfg_q.encoder_present  = 1'b1;
      prev_count_q           = '0;
      err_sum_q              = '0;
      prev_err_q             = '0;
      pwm_acc_q              = '0;
      pwm_expected.delete();
      fail_count             = 0;
      pending_o              = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegKpGain:     cfg_q.kp_gain          = cfg_data_i[GainW-1:0];
          RegKdGain:     cfg_q.kd_gain          = cfg_data_i[GainW-1:0];
          RegKiGain:     cfg_q.ki_gain          = cfg_data_i[GainW-1:0];
          RegRange:      cfg_q.encoder_range    = cfg_data_i[CountW-1:0];
          RegMaxPwm:     cfg_q.max_pwm          = cfg_data_i[LimW-1:0];
          RegVelScale:   cfg_q.velocity_scale   = cfg_data_i;
          RegFfGain:     cfg_q.feedforward_gain = cfg_data_i;
          RegEncPresent: cfg_q.encoder_present  = cfg_data_i[0];
          default: ;
        endcase
      end

      if (out_i.valid && out_i.ready) begin
        if (pwm_expected.size() == 0) begin
          report_mismatch($sformatf("pwm_value %0d with no transaction outstanding",
                                    out_i.pwm_value));
        end else begin
          pwm_want = pwm_expected.pop_front();
          if (out_i.pwm_value !== pwm_want) begin
            report_mismatch($sformatf("pwm_value %0d, predicted %0d",
                                      out_i.pwm_value, pwm_want));
          end
        end
      end

      if (in_i.valid && in_i.ready) begin
        pwm_expected.push_back(predict_pwm(in_i.encoder_count, in_i.target_velocity));
      end
      pending_o = pwm_expected.size();
    end
  end

endmodule

/* verif/tb_top.sv */
// Top of the encoder velocity PID/PWM core testbench.
// Drives reset, configuration and input transactions with random idling, and
// gives the verdict. Depends on evpp_pkg, the channel interfaces, evpp_checker and the core.
`timescale 1ns / 1ps

module tb_top;
  import evpp_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 12;
  localparam int unsigned ItemsPerSet   = 170;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  evpp_in_if  cmd_if ();
  evpp_out_if pwm_if ();

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned fail_count;
  int unsigned pending_results;
  cfg_t        cur_cfg;

  encoder_velocity_pid_pwm_core i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (cmd_if),
    .out_o      (pwm_if)
  );

  evpp_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_i         (cmd_if),
    .out_i        (pwm_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  // Clock of 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: ready is redrawn every cycle from the current idle rate.
  initial begin
    pwm_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      pwm_if.ready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Watchdog: ends the run when nothing has been accepted for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (pwm_if.valid && pwm_if.ready) || cfg_we) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Offer one input transaction after a random gap and hold it until accepted.
  task automatic send_item(input logic [CountW-1:0] count, input logic [VelW-1:0] target);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid           <= 1'b1;
    cmd_if.encoder_count   <= count;
    cmd_if.target_velocity <= target;
    do @(posedge clk); while (!cmd_if.ready);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Write every register back to back; only called while the core is idle.
  task automatic write_config(input cfg_t c);
    cur_cfg = c;
    write_reg(RegKpGain,     CfgDataW'(c.kp_gain));
    write_reg(RegKdGain,     CfgDataW'(c.kd_gain));
    write_reg(RegKiGain,     CfgDataW'(c.ki_gain));
    write_reg(RegRange,      CfgDataW'(c.encoder_range));
    write_reg(RegMaxPwm,     CfgDataW'(c.max_pwm));
    write_reg(RegVelScale,   CfgDataW'(c.velocity_scale));
    write_reg(RegFfGain,     CfgDataW'(c.feedforward_gain));
    write_reg(RegEncPresent, CfgDataW'(c.encoder_present));
    cfg_we <= 1'b0;
  endtask

  // Stop offering and wait, away from the clock edge, until every result is in.
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int unsigned     ph;
    int unsigned     set_nr;
    longint          span;
    longint          step;
    longint          pos;
    longint          tgt_l;
    longint unsigned rng;
    logic [31:0]     cnt;
    logic [31:0]     tgt;

    rst_n                  = 1'b0;
    cfg_we                 <= 1'b0;
    cfg_idx                <= '0;
    cfg_data               <= '0;
    cmd_if.valid           <= 1'b0;
    cmd_if.encoder_count   <= '0;
    cmd_if.target_velocity <= '0;
    tx_idle_pct            = 33;
    rx_idle_pct            = 68;
    pos                    = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: all gains zero, error sum still integrates.
    send_item(32'd0, 32'h7FFF_FFFF);
    send_item(32'd0, 32'h8000_0000);
    drain_results();

    // Closed loop at a typical setting: band crossings in both directions.
    write_config('{kp_gain: 16'd3, kd_gain: 16'd2, ki_gain: 16'd1,
                   encoder_range: 32'd4096, max_pwm: 15'd1000,
                   velocity_scale: 32'd100532, feedforward_gain: 32'h0001_0000,
                   encoder_present: 1'b1});
    send_item(32'd100,  32'd0);
    send_item(32'd3900, 32'd0);
    send_item(32'd4000, 32'h0001_8000);
    send_item(32'd50,   32'd0);
    send_item(32'd4096, 32'd0);
    send_item(32'd4097, 32'd0);
    send_item(32'd409,  32'd0);
    send_item(32'd3687, 32'd0);
    send_item(32'd410,  32'd0);
    send_item(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'h8000_0000);
    drain_results();

    // Zero range, largest scale and gains: velocity saturation both ways.
    write_config('{kp_gain: 16'hFFFF, kd_gain: 16'hFFFF, ki_gain: 16'hFFFF,
                   encoder_range: 32'd0, max_pwm: 15'd32767,
                   velocity_scale: 32'hFFFF_FFFF, feedforward_gain: 32'd0,
                   encoder_present: 1'b1});
    send_item(32'd0,         32'd0);
    send_item(32'hFFFF_FFFF, 32'd0);
    send_item(32'd0,         32'h7FFF_FFFF);
    send_item(32'd1,         32'h8000_0000);
    drain_results();

    // Open loop at the largest feed-forward gain, truncation toward zero included.
    write_config('{kp_gain: 16'd0, kd_gain: 16'd0, ki_gain: 16'd0,
                   encoder_range: 32'hFFFF_FFFF, max_pwm: 15'd32767,
                   velocity_scale: 32'd0, feedforward_gain: 32'hFFFF_FFFF,
                   encoder_present: 1'b0});
    send_item(32'd5, 32'h7FFF_FFFF);
    send_item(32'd6, 32'h8000_0000);
    send_item(32'd7, 32'hFFFF_FFFF);
    send_item(32'd8, 32'd1);
    send_item(32'd9, 32'hFFFF_0000);
    drain_results();

    // Zero limit: error sum and drive are pinned to zero.
    write_config('{kp_gain: 16'd1, kd_gain: 16'd1, ki_gain: 16'd1,
                   encoder_range: 32'd1, max_pwm: 15'd0,
                   velocity_scale: 32'd100532, feedforward_gain: 32'd0,
                   encoder_present: 1'b1});
    send_item(32'd10, 32'h0100_0000);
    send_item(32'd20, 32'hFF00_0000);
    drain_results();

    // Random part: three idling phases, several settings in each.
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 33;
          rx_idle_pct = 68;
        end
        1: begin
          tx_idle_pct = 68;
          rx_idle_pct = 33;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase

      for (set_nr = 0; set_nr < 4; set_nr++) begin
        // Mostly small gains so the loop stays out of saturation, extremes now and then.
        cur_cfg.kp_gain = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 12));
        cur_cfg.kd_gain = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 12));
        cur_cfg.ki_gain = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 4));
        case ($urandom_range(0, 9))
          0:       cur_cfg.encoder_range = 32'd0;
          1:       cur_cfg.encoder_range = 32'd1;
          2:       cur_cfg.encoder_range = 32'hFFFF_FFFF;
          3:       cur_cfg.encoder_range = $urandom();
          default: cur_cfg.encoder_range = (32'd1 << $urandom_range(2, 16))
                                         + 32'($urandom_range(0, 3));
        endcase
        case ($urandom_range(0, 11))
          0:       cur_cfg.max_pwm = 15'd0;
          1:       cur_cfg.max_pwm = 15'd1;
          2:       cur_cfg.max_pwm = 15'd32767;
          default: cur_cfg.max_pwm = 15'($urandom_range(50, 5000));
        endcase
        rng = cur_cfg.encoder_range;
        case ($urandom_range(0, 9))
          0:       cur_cfg.velocity_scale = 32'd0;
          1:       cur_cfg.velocity_scale = 32'hFFFF_FFFF;
          2:       cur_cfg.velocity_scale = $urandom();
          default: cur_cfg.velocity_scale = (rng != 0) ? 32'((64'd6283 << 16) / rng) : $urandom();
        endcase
        case ($urandom_range(0, 5))
          0:       cur_cfg.feedforward_gain = 32'd0;
          1:       cur_cfg.feedforward_gain = 32'hFFFF_FFFF;
          2:       cur_cfg.feedforward_gain = $urandom();
          default: cur_cfg.feedforward_gain = 32'($urandom_range(0, 32'h00FF_FFFF));
        endcase
        cur_cfg.encoder_present = ($urandom_range(0, 3) != 0);
        write_config(cur_cfg);
        pos = 0;

        repeat (ItemsPerSet) begin
          if ($urandom_range(0, 4) != 0 && rng > 1) begin
            // Plausible motion: a bounded step round the turn, target near that speed.
            span = longint'(rng / 8) + 1;
            step = longint'($urandom_range(0, 32'(2 * span))) - span;
            pos  = pos + step;
            if (pos < 0) begin
              pos = pos + longint'(rng);
            end else if (pos >= longint'(rng)) begin
              pos = pos - longint'(rng);
            end
            cnt   = ($urandom_range(0, 19) == 0) ? 32'(rng) : 32'(pos);
            tgt_l = step * longint'(cur_cfg.velocity_scale)
                  + (longint'($urandom_range(0, 400)) - 200) * 65536
                  + longint'($urandom_range(0, 65535));
            if (tgt_l > 64'sd2147483647) begin
              tgt_l = 64'sd2147483647;
            end else if (tgt_l < -64'sd2147483648) begin
              tgt_l = -64'sd2147483648;
            end
            tgt = tgt_l[31:0];
          end else begin
            // Noise: arbitrary counts and targets break the motion sequence.
            cnt = $urandom();
            tgt = $urandom();
          end
          send_item(cnt, tgt);
        end
        drain_results();
      end
    end

    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/evpp_pkg.sv
rtl/evpp_in_if.sv
rtl/evpp_out_if.sv
rtl/evpp_cfg_regs.sv
rtl/evpp_ctrl.sv
rtl/evpp_dp.sv
rtl/encoder_velocity_pid_pwm_core.sv
verif/evpp_checker.sv
verif/tb_top.sv
